[rtl/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and codes for the bounded LIFO stack: operation and status
// codes, the failure word and the stream field layout.
// ----------------------------------------------------------------------------
package bls_pkg;

	localparam int WORD_W   = 32;
	localparam int CAP_W    = 5;
	localparam int POS_W    = 5;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// input tdata layout
	localparam int IN_TDATA_W  = 40;
	localparam int IN_OP_LO    = 0;
	localparam int IN_VAL_LO   = IN_OP_LO + OP_W;
	localparam int IN_POS_LO   = IN_VAL_LO + WORD_W;

	// output tdata layout
	localparam int OUT_TDATA_W  = 40;
	localparam int OUT_DATA_LO  = 0;
	localparam int OUT_STAT_LO  = OUT_DATA_LO + WORD_W;
	localparam int OUT_FULL_BIT = OUT_STAT_LO + STATUS_W;
	localparam int OUT_EMPT_BIT = OUT_FULL_BIT + 1;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_EMPT_BIT - 1;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
	localparam logic [OP_W-1:0] OP_TOP  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

	localparam logic [WORD_W-1:0] FAIL_WORD = '1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	// result fields that wait for the memory read
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                is_full;
		logic                is_empty;
		logic                use_mem;
	} res_ctrl_t;

endpackage

[rtl/bounded_lifo_stack.sv]
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack of signed 32-bit words with push, pop, peek and top.
// ----------------------------------------------------------------------------
// The stack takes one request per cycle and returns one result per request,
// in order. A request is decoded against the live entry count at the input
// transfer: push writes its word into the memory at that edge, while pop,
// peek and top issue a read. The memory returns the word in the next cycle,
// and the result loads the output register once that register is free or
// drains, so a result passes the read stage and the output register before
// it is offered. The sustained rate is one request per cycle as long as the
// output is taken. While the output is held off, one result waits in the
// output register and one in the read stage, and input ready drops until the
// output drains. The count is updated at the input transfer, so the next
// request already sees it, and a push is in the memory before any later read
// can be issued. Capacity is min(capacity register, DEPTH) and may be lowered
// below the current count: stored words stay readable and pushes overflow.
// The memory needs no clearing after reset: only written words are output.
// ----------------------------------------------------------------------------
module bounded_lifo_stack #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// capacity register write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bls_pkg::CAP_W-1:0]         cfg_data,
	// requests
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [1:0] op, [33:2] push_value, [38:34] position, [39] zero
	input  logic [bls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [31:0] read_data, [33:32] status, [34] is_full, [35] is_empty,
	// [39:36] zero
	output logic [bls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int W  = (CW > bls_pkg::CAP_W) ? CW : bls_pkg::CAP_W;

	// request fields
	logic [bls_pkg::OP_W-1:0]          op;
	logic signed [bls_pkg::WORD_W-1:0] push_value;
	logic [bls_pkg::POS_W-1:0]         position;

	assign op         = s_axis_tdata[bls_pkg::IN_OP_LO +: bls_pkg::OP_W];
	assign push_value = s_axis_tdata[bls_pkg::IN_VAL_LO +: bls_pkg::WORD_W];
	assign position   = s_axis_tdata[bls_pkg::IN_POS_LO +: bls_pkg::POS_W];

	// state
	logic [bls_pkg::CAP_W-1:0] capacity_q;
	logic [CW-1:0]             count_q;

	// read stage and output register
	logic                              valid_s1;
	bls_pkg::res_ctrl_t                ctrl_s1;
	logic signed [bls_pkg::WORD_W-1:0] rdata;
	logic                              out_valid_q;
	logic [bls_pkg::OUT_TDATA_W-1:0]   out_data_q;

	// decode
	logic               accept;
	logic               adv_s1;
	logic [W-1:0]       cap_w;
	logic [W-1:0]       cnt_w;
	logic [W-1:0]       pos_w;
	logic [W-1:0]       diff_w;
	logic [CW-1:0]      count_nxt;
	logic               we;
	logic [AW-1:0]      raddr;
	bls_pkg::res_ctrl_t ctrl_nxt;
	logic signed [bls_pkg::WORD_W-1:0] read_data;

	assign cfg_ready = 1'b1;

	// advance the read stage whenever the output register is free or drains
	assign adv_s1        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		cap_w = (W'(capacity_q) > W'(DEPTH)) ? W'(DEPTH) : W'(capacity_q);
		cnt_w = W'(count_q);
		pos_w = W'(position);
		// peek counts from the top; pop and top address the top itself
		diff_w = cnt_w - ((op == bls_pkg::OP_PEEK) ? pos_w : W'(1));
		raddr  = diff_w[AW-1:0];

		count_nxt        = count_q;
		we               = 1'b0;
		ctrl_nxt.status  = bls_pkg::ST_OK;
		ctrl_nxt.use_mem = 1'b0;

		case (op)
			bls_pkg::OP_PUSH: begin
				if (cnt_w >= cap_w) begin
					ctrl_nxt.status = bls_pkg::ST_OVERFLOW;
				end else begin
					we        = 1'b1;
					count_nxt = CW'(count_q + CW'(1));
				end
			end
			bls_pkg::OP_POP: begin
				if (count_q == '0) begin
					ctrl_nxt.status = bls_pkg::ST_UNDERFLOW;
				end else begin
					ctrl_nxt.use_mem = 1'b1;
					count_nxt        = CW'(count_q - CW'(1));
				end
			end
			bls_pkg::OP_PEEK: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					ctrl_nxt.status = bls_pkg::ST_INVALID;
				end else begin
					ctrl_nxt.use_mem = 1'b1;
				end
			end
			default: begin
				if (count_q == '0) begin
					ctrl_nxt.status = bls_pkg::ST_UNDERFLOW;
				end else begin
					ctrl_nxt.use_mem = 1'b1;
				end
			end
		endcase

		ctrl_nxt.is_full  = (W'(count_nxt) >= cap_w);
		ctrl_nxt.is_empty = (count_nxt == '0);
	end

	bls_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && we),
		.waddr (count_q[AW-1:0]),
		.wdata (push_value),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bls_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nxt;
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// status and flags travel beside the memory read
	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_nxt;
		end
	end

	// failed requests and pushes return the all-ones word
	assign read_data = ctrl_s1.use_mem ? rdata : bls_pkg::FAIL_WORD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			out_data_q <= {{bls_pkg::OUT_PAD_W{1'b0}}, ctrl_s1.is_empty,
				ctrl_s1.is_full, ctrl_s1.status, read_data};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[rtl/bls_ram.sv]
// ----------------------------------------------------------------------------
// bls_ram
// Word store of the stack: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bls_ram #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  logic signed [bls_pkg::WORD_W-1:0] wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output logic signed [bls_pkg::WORD_W-1:0] rdata
);

	logic signed [bls_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/bls_checker.sv]
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks of the stack results, bound to the top level.
// ----------------------------------------------------------------------------
module bls_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [bls_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [bls_pkg::WORD_W-1:0]   read_data;
	logic [bls_pkg::STATUS_W-1:0] status;
	logic                         is_full;
	logic                         is_empty;

	assign read_data = m_axis_tdata[bls_pkg::OUT_DATA_LO +: bls_pkg::WORD_W];
	assign status    = m_axis_tdata[bls_pkg::OUT_STAT_LO +: bls_pkg::STATUS_W];
	assign is_full   = m_axis_tdata[bls_pkg::OUT_FULL_BIT];
	assign is_empty  = m_axis_tdata[bls_pkg::OUT_EMPT_BIT];

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// overflow only happens at or above capacity, which stays after the push
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == bls_pkg::ST_OVERFLOW |-> is_full)
		else $error("overflow without full");

	// underflow leaves the stack empty
	a_udf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == bls_pkg::ST_UNDERFLOW |-> is_empty)
		else $error("underflow without empty");

	// every failure returns the all-ones word
	a_fail_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status != bls_pkg::ST_OK |-> read_data == bls_pkg::FAIL_WORD)
		else $error("failed request returned data");

endmodule

bind bounded_lifo_stack bls_checker u_bls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
